// ===== sv/tcr_pkg.sv =====
package tcr_pkg;

  localparam int SPAN_W   = 16;
  localparam int PANEL_W  = 12;
  localparam int WEIGHT_W = 5;
  localparam int QUOT_W   = 12;
  localparam int MUL_W    = SPAN_W + PANEL_W;
  localparam int FIELD_W  = 12;

  typedef enum logic [2:0] {
    CFG_POWERED_ON,
    CFG_RESUME_MODE,
    CFG_SENSOR_X_SPAN,
    CFG_SENSOR_Y_SPAN,
    CFG_PANEL_WIDTH,
    CFG_PANEL_HEIGHT,
    CFG_NEW_WEIGHT,
    CFG_OLD_WEIGHT
  } cfg_index_t;

  localparam logic EV_PRESS   = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

endpackage

// ===== sv/tcr_mul.sv =====
module tcr_mul import tcr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SPAN_W-1:0]  a,
  input  logic [PANEL_W-1:0] b,
  output logic               done,
  output logic [MUL_W-1:0]   prod
);

  localparam int CNT_W = $clog2(PANEL_W + 1);

  logic [SPAN_W-1:0]  a_r;
  logic [PANEL_W-1:0] b_sh;
  logic [CNT_W-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == CNT_W'(1));
      if (start) begin
        prod <= '0;
        a_r  <= a;
        b_sh <= b;
        cnt  <= CNT_W'(PANEL_W);
      end else if (cnt != '0) begin
        prod <= {prod[MUL_W-2:0], 1'b0} + (b_sh[PANEL_W-1] ? MUL_W'(a_r) : '0);
        b_sh <= {b_sh[PANEL_W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== sv/tcr_div.sv =====
module tcr_div import tcr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MUL_W-1:0]  num,
  input  logic [SPAN_W-1:0] den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [SPAN_W-1:0] rem;
  logic [QUOT_W-1:0] lo;
  logic [CNT_W-1:0]  cnt;
  logic [SPAN_W:0]   trial;
  logic              ge;

  assign trial = {rem, lo[QUOT_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == CNT_W'(1));
      if (start) begin
        rem  <= num[MUL_W-1:QUOT_W];
        lo   <= num[QUOT_W-1:0];
        quot <= '0;
        cnt  <= CNT_W'(QUOT_W);
      end else if (cnt != '0) begin
        rem  <= ge ? SPAN_W'(trial - {1'b0, den}) : trial[SPAN_W-1:0];
        lo   <= {lo[QUOT_W-2:0], 1'b0};
        quot <= {quot[QUOT_W-2:0], ge};
        cnt  <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== sv/tcr_blend.sv =====
module tcr_blend import tcr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] coord,
  input  logic [COORD_BITS-1:0] prev,
  input  logic [WEIGHT_W-1:0]   new_weight,
  input  logic [WEIGHT_W-1:0]   old_weight,
  output logic                  done,
  output logic [COORD_BITS-1:0] result
);

  localparam int ACC_W = COORD_BITS + WEIGHT_W + 1;
  localparam int SH_W  = ACC_W - 4;
  localparam int CNT_W = $clog2(WEIGHT_W + 1);
  localparam logic [SH_W-1:0] COORD_MAX_W = SH_W'((32'd1 << COORD_BITS) - 1);

  logic [COORD_BITS-1:0] c_r;
  logic [COORD_BITS-1:0] p_r;
  logic [WEIGHT_W-1:0]   nw_sh;
  logic [WEIGHT_W-1:0]   ow_sh;
  logic [ACC_W-1:0]      acc;
  logic [CNT_W-1:0]      cnt;
  logic [SH_W-1:0]       shifted;

  assign shifted = acc[ACC_W-1:4];
  assign result  = (shifted > COORD_MAX_W) ? COORD_MAX_W[COORD_BITS-1:0]
                                           : shifted[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == CNT_W'(1));
      if (start) begin
        acc   <= '0;
        c_r   <= coord;
        p_r   <= prev;
        nw_sh <= new_weight;
        ow_sh <= old_weight;
        cnt   <= CNT_W'(WEIGHT_W);
      end else if (cnt != '0) begin
        acc   <= {acc[ACC_W-2:0], 1'b0}
               + (nw_sh[WEIGHT_W-1] ? ACC_W'(c_r) : '0)
               + (ow_sh[WEIGHT_W-1] ? ACC_W'(p_r) : '0);
        nw_sh <= {nw_sh[WEIGHT_W-2:0], 1'b0};
        ow_sh <= {ow_sh[WEIGHT_W-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== sv/touch_report_conditioner_unit.sv =====
// Conditions one touch-controller sample per beat into at most one press or release
// event. A sample that gives a press holds off the input from its acceptance until its
// event enters the output register: x and y are scaled in parallel by a bit-serial
// multiplier (one panel-resolution bit a cycle) and then a restoring divider (one
// quotient bit a cycle), then smoothed by a bit-serial weighting unit unless it is the
// first press, and the event then waits in the hold state until the output register is
// free. A release goes straight to the hold state, and a sample that gives no event
// leaves the input ready. A new sample is taken while an event waits in the output
// register, but the next event is held back until that beat has been accepted.
module touch_report_conditioner_unit import tcr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int RAW_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic               read_ok,
  input  logic [2:0]         touch_count,
  input  logic [15:0]        raw_x,
  input  logic [15:0]        raw_y,
  output logic               event_valid,
  input  logic               event_ready,
  output logic               event_kind,
  output logic [FIELD_W-1:0] panel_x,
  output logic [FIELD_W-1:0] panel_y,
  output logic               pressure,
  output logic [FIELD_W-1:0] smooth_x,
  output logic [FIELD_W-1:0] smooth_y
);

  localparam int SAT_W = QUOT_W + 5;
  localparam logic [SPAN_W-1:0] RAW_MASK = SPAN_W'((32'd1 << RAW_BITS) - 1);
  localparam logic [SAT_W-1:0] COORD_MAX_W = SAT_W'((32'd1 << COORD_BITS) - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_BLEND,
    ST_HOLD
  } state_t;

  state_t state;

  logic                  powered_on;
  logic                  resume_mode;
  logic [SPAN_W-1:0]     sensor_x_span;
  logic [SPAN_W-1:0]     sensor_y_span;
  logic [PANEL_W-1:0]    panel_width;
  logic [PANEL_W-1:0]    panel_height;
  logic [WEIGHT_W-1:0]   new_weight;
  logic [WEIGHT_W-1:0]   old_weight;

  logic                  finger_down;
  logic                  first_press;
  logic [COORD_BITS-1:0] filtered_x;
  logic [COORD_BITS-1:0] filtered_y;
  logic                  pend_kind;
  logic [COORD_BITS-1:0] pend_x;
  logic [COORD_BITS-1:0] pend_y;

  logic [SPAN_W-1:0]     rx;
  logic [SPAN_W-1:0]     ry;
  logic [SPAN_W-1:0]     dy;
  logic                  accept;
  logic                  in_span;
  logic                  press;
  logic                  release_now;
  logic                  out_free;

  logic                  mulx_done;
  logic                  muly_done;
  logic [MUL_W-1:0]      prod_x;
  logic [MUL_W-1:0]      prod_y;
  logic                  divx_done;
  logic                  divy_done;
  logic [QUOT_W-1:0]     quot_x;
  logic [QUOT_W-1:0]     quot_y;
  logic [COORD_BITS-1:0] sat_x;
  logic [COORD_BITS-1:0] sat_y;
  logic                  blendx_done;
  logic                  blendy_done;
  logic [COORD_BITS-1:0] blend_x;
  logic [COORD_BITS-1:0] blend_y;

  assign rx           = raw_x & RAW_MASK;
  assign ry           = raw_y & RAW_MASK;
  assign dy           = sensor_y_span - ry;
  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign in_span      = (rx != '0) && (rx < sensor_x_span) &&
                        (ry != '0) && (ry < sensor_y_span);
  assign press        = accept && powered_on && read_ok &&
                        (touch_count != 3'd0) && in_span;
  assign release_now  = accept && finger_down &&
                        ((!powered_on && resume_mode) ||
                         (powered_on && read_ok && (touch_count == 3'd0)));
  assign out_free     = !event_valid || event_ready;

  assign sat_x = ({5'b0, quot_x} > COORD_MAX_W) ? COORD_MAX_W[COORD_BITS-1:0]
                                                : COORD_BITS'(quot_x);
  assign sat_y = ({5'b0, quot_y} > COORD_MAX_W) ? COORD_MAX_W[COORD_BITS-1:0]
                                                : COORD_BITS'(quot_y);

  tcr_mul u_mul_x (
    .clk(clk), .rst(rst), .start(press), .a(rx), .b(panel_width),
    .done(mulx_done), .prod(prod_x)
  );

  tcr_mul u_mul_y (
    .clk(clk), .rst(rst), .start(press), .a(dy), .b(panel_height),
    .done(muly_done), .prod(prod_y)
  );

  tcr_div u_div_x (
    .clk(clk), .rst(rst), .start(mulx_done), .num(prod_x), .den(sensor_x_span),
    .done(divx_done), .quot(quot_x)
  );

  tcr_div u_div_y (
    .clk(clk), .rst(rst), .start(muly_done), .num(prod_y), .den(sensor_y_span),
    .done(divy_done), .quot(quot_y)
  );

  tcr_blend #(.COORD_BITS(COORD_BITS)) u_blend_x (
    .clk(clk), .rst(rst), .start(divx_done && !first_press), .coord(sat_x),
    .prev(filtered_x), .new_weight(new_weight), .old_weight(old_weight),
    .done(blendx_done), .result(blend_x)
  );

  tcr_blend #(.COORD_BITS(COORD_BITS)) u_blend_y (
    .clk(clk), .rst(rst), .start(divy_done && !first_press), .coord(sat_y),
    .prev(filtered_y), .new_weight(new_weight), .old_weight(old_weight),
    .done(blendy_done), .result(blend_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      powered_on    <= 1'b1;
      resume_mode   <= 1'b0;
      sensor_x_span <= 16'd3537;
      sensor_y_span <= 16'd5880;
      panel_width   <= 12'd640;
      panel_height  <= 12'd960;
      new_weight    <= 5'd6;
      old_weight    <= 5'd10;
      finger_down   <= 1'b0;
      filtered_x    <= '0;
      filtered_y    <= '0;
      event_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_POWERED_ON:    powered_on    <= cfg_data[0];
          CFG_RESUME_MODE:   resume_mode   <= cfg_data[0];
          CFG_SENSOR_X_SPAN: sensor_x_span <= cfg_data;
          CFG_SENSOR_Y_SPAN: sensor_y_span <= cfg_data;
          CFG_PANEL_WIDTH:   panel_width   <= cfg_data[PANEL_W-1:0];
          CFG_PANEL_HEIGHT:  panel_height  <= cfg_data[PANEL_W-1:0];
          CFG_NEW_WEIGHT:    new_weight    <= cfg_data[WEIGHT_W-1:0];
          CFG_OLD_WEIGHT:    old_weight    <= cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (event_valid && event_ready && (state != ST_HOLD)) begin
        event_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (press) begin
            first_press <= !finger_down;
            finger_down <= 1'b1;
            state       <= ST_MUL;
          end else if (release_now) begin
            finger_down <= 1'b0;
            pend_kind   <= EV_RELEASE;
            pend_x      <= '0;
            pend_y      <= '0;
            state       <= ST_HOLD;
          end
        end
        ST_MUL: begin
          if (mulx_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (divx_done) begin
            pend_kind <= EV_PRESS;
            pend_x    <= sat_x;
            pend_y    <= sat_y;
            if (first_press) begin
              filtered_x <= sat_x;
              filtered_y <= sat_y;
              state      <= ST_HOLD;
            end else begin
              state <= ST_BLEND;
            end
          end
        end
        ST_BLEND: begin
          if (blendx_done && blendy_done) begin
            filtered_x <= blend_x;
            filtered_y <= blend_y;
            state      <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            event_valid <= 1'b1;
            event_kind  <= pend_kind;
            pressure    <= (pend_kind == EV_PRESS);
            panel_x     <= FIELD_W'(pend_x);
            panel_y     <= FIELD_W'(pend_y);
            smooth_x    <= FIELD_W'(filtered_x);
            smooth_y    <= FIELD_W'(filtered_y);
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tcr_pkg::*;

  localparam int QUIET_CYCLES   = 48;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 64;
  localparam longint unsigned COORD_LIMIT = (64'd1 << FIELD_W) - 1;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] px;
    logic [FIELD_W-1:0] py;
    logic               pr;
    logic [FIELD_W-1:0] sx;
    logic [FIELD_W-1:0] sy;
  } touch_event_t;

  typedef enum logic { ROW_SAMPLE, ROW_CONFIG } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    cfg_index_t   idx;
    logic [15:0]  data;
    logic         ok;
    logic [2:0]   cnt;
    logic [15:0]  rx;
    logic [15:0]  ry;
    bit           fixed;
    bit           fixed_has;
    touch_event_t ev;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               sample_valid;
  logic               sample_ready;
  logic               read_ok;
  logic [2:0]         touch_count;
  logic [15:0]        raw_x;
  logic [15:0]        raw_y;
  logic               event_valid;
  logic               event_ready;
  logic               event_kind;
  logic [FIELD_W-1:0] panel_x;
  logic [FIELD_W-1:0] panel_y;
  logic               pressure;
  logic [FIELD_W-1:0] smooth_x;
  logic [FIELD_W-1:0] smooth_y;

  logic               cfg_on;
  logic               cfg_resume;
  logic [15:0]        cfg_sx;
  logic [15:0]        cfg_sy;
  logic [11:0]        cfg_pw;
  logic [11:0]        cfg_ph;
  logic [4:0]         cfg_nw;
  logic [4:0]         cfg_ow;
  logic               finger_down_q;
  logic [FIELD_W-1:0] filt_x;
  logic [FIELD_W-1:0] filt_y;

  touch_event_t expected_events[$];
  stim_row_t    directed_rows[$];
  int           error_count;
  int           idle_cycles;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           block_idle;
  bit           cur_fixed;
  bit           cur_fixed_has;
  touch_event_t cur_fixed_ev;

  touch_report_conditioner_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .read_ok      (read_ok),
    .touch_count  (touch_count),
    .raw_x        (raw_x),
    .raw_y        (raw_y),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_kind   (event_kind),
    .panel_x      (panel_x),
    .panel_y      (panel_y),
    .pressure     (pressure),
    .smooth_x     (smooth_x),
    .smooth_y     (smooth_y)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    event_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [FIELD_W-1:0] clamp_coord(input longint unsigned v);
    return (v > COORD_LIMIT) ? COORD_LIMIT[FIELD_W-1:0] : v[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] blend_coord(input logic [FIELD_W-1:0] coord,
                                                     input logic [FIELD_W-1:0] prev);
    longint unsigned nw, ow, c, p;
    nw = 64'(cfg_nw);
    ow = 64'(cfg_ow);
    c  = 64'(coord);
    p  = 64'(prev);
    return clamp_coord((nw * c + ow * p) >> 4);
  endfunction

  function automatic touch_event_t make_event(input logic kind, input int px, input int py,
                                              input logic pr, input int sx, input int sy);
    touch_event_t ev;
    ev.kind = kind;
    ev.px   = px[FIELD_W-1:0];
    ev.py   = py[FIELD_W-1:0];
    ev.pr   = pr;
    ev.sx   = sx[FIELD_W-1:0];
    ev.sy   = sy[FIELD_W-1:0];
    return ev;
  endfunction

  // Works out the event for one accepted sample and advances the tracked touch state.
  function automatic bit predict_touch(input logic ok, input logic [2:0] cnt,
                                       input logic [15:0] rx, input logic [15:0] ry,
                                       output touch_event_t ev);
    longint unsigned lrx, lry, lsx, lsy, lpw, lph;
    logic [FIELD_W-1:0] px, py;
    ev = '0;
    if (!cfg_on) begin
      if (finger_down_q && cfg_resume) begin
        finger_down_q = 1'b0;
        ev = make_event(EV_RELEASE, 0, 0, 1'b0, int'(filt_x), int'(filt_y));
        return 1'b1;
      end
      return 1'b0;
    end
    if (!ok) begin
      return 1'b0;
    end
    if (cnt != 3'd0) begin
      if (!(rx > 0 && rx < cfg_sx && ry > 0 && ry < cfg_sy)) begin
        return 1'b0;
      end
      lrx = 64'(rx);
      lry = 64'(ry);
      lsx = 64'(cfg_sx);
      lsy = 64'(cfg_sy);
      lpw = 64'(cfg_pw);
      lph = 64'(cfg_ph);
      px = clamp_coord(lrx * lpw / lsx);
      py = clamp_coord((lsy - lry) * lph / lsy);
      if (!finger_down_q) begin
        finger_down_q = 1'b1;
        filt_x = px;
        filt_y = py;
      end else begin
        filt_x = blend_coord(px, filt_x);
        filt_y = blend_coord(py, filt_y);
      end
      ev = make_event(EV_PRESS, int'(px), int'(py), 1'b1, int'(filt_x), int'(filt_y));
      return 1'b1;
    end
    if (finger_down_q) begin
      finger_down_q = 1'b0;
      ev = make_event(EV_RELEASE, 0, 0, 1'b0, int'(filt_x), int'(filt_y));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic note_error(input string what, input touch_event_t want,
                            input touch_event_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%s: expected kind=%0d x=%0d y=%0d p=%0d sx=%0d sy=%0d", what, want.kind,
               want.px, want.py, want.pr, want.sx, want.sy);
      $display("  got kind=%0d x=%0d y=%0d p=%0d sx=%0d sy=%0d at %0t", got.kind, got.px,
               got.py, got.pr, got.sx, got.sy, $realtime);
    end
  endtask

  always @(posedge clk) begin : event_check
    touch_event_t want, got;
    bit has;
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        has = predict_touch(read_ok, touch_count, raw_x, raw_y, want);
        if (cur_fixed) begin
          has  = cur_fixed_has;
          want = cur_fixed_ev;
        end
        if (has) begin
          expected_events.push_back(want);
        end
      end
      if (event_valid && event_ready) begin
        got.kind = event_kind;
        got.px   = panel_x;
        got.py   = panel_y;
        got.pr   = pressure;
        got.sx   = smooth_x;
        got.sy   = smooth_y;
        if (expected_events.size() == 0) begin
          note_error("Event beat with none expected", '0, got);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            note_error("Event mismatch", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (event_valid && event_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic ok, input logic [2:0] cnt, input logic [15:0] rx,
                             input logic [15:0] ry, input bit fixed, input bit fixed_has,
                             input touch_event_t fixed_ev);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid  <= 1'b1;
    read_ok       <= ok;
    touch_count   <= cnt;
    raw_x         <= rx;
    raw_y         <= ry;
    cur_fixed     = fixed;
    cur_fixed_has = fixed_has;
    cur_fixed_ev  = fixed_ev;
    block_idle    = 1'b0;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic wait_for_quiet();
    if (!block_idle) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clk);
      repeat (QUIET_CYCLES) @(negedge clk);
      block_idle = 1'b1;
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
    wait_for_quiet();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_POWERED_ON:    cfg_on     = data[0];
      CFG_RESUME_MODE:   cfg_resume = data[0];
      CFG_SENSOR_X_SPAN: cfg_sx     = data;
      CFG_SENSOR_Y_SPAN: cfg_sy     = data;
      CFG_PANEL_WIDTH:   cfg_pw     = data[11:0];
      CFG_PANEL_HEIGHT:  cfg_ph     = data[11:0];
      CFG_NEW_WEIGHT:    cfg_nw     = data[4:0];
      CFG_OLD_WEIGHT:    cfg_ow     = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic void add_write(input cfg_index_t idx, input logic [15:0] data);
    stim_row_t row;
    row.kind      = ROW_CONFIG;
    row.idx       = idx;
    row.data      = data;
    row.ok        = 1'b0;
    row.cnt       = 3'd0;
    row.rx        = 16'd0;
    row.ry        = 16'd0;
    row.fixed     = 1'b0;
    row.fixed_has = 1'b0;
    row.ev        = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic ok, input logic [2:0] cnt,
                                      input logic [15:0] rx, input logic [15:0] ry,
                                      input bit fixed, input bit has, input touch_event_t ev);
    stim_row_t row;
    row.kind      = ROW_SAMPLE;
    row.idx       = CFG_POWERED_ON;
    row.data      = 16'd0;
    row.ok        = ok;
    row.cnt       = cnt;
    row.rx        = rx;
    row.ry        = ry;
    row.fixed     = fixed;
    row.fixed_has = has;
    row.ev        = ev;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [15:0] pick_span();
    case ($urandom_range(4))
      0:       return 16'hFFFF;
      1:       return 16'($urandom_range(64, 2));
      2:       return 16'($urandom_range(4000, 65));
      3:       return 16'($urandom_range(65535, 4001));
      default: return 16'd1;
    endcase
  endfunction

  function automatic logic [15:0] pick_panel();
    case ($urandom_range(3))
      0:       return 16'd1;
      1:       return 16'd4095;
      default: return 16'($urandom_range(4095, 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'd16;
      default: return 16'($urandom_range(16, 0));
    endcase
  endfunction

  function automatic logic [15:0] pick_raw(input logic [15:0] span);
    if (span >= 16'd2) begin
      return 16'($urandom_range(span - 16'd1, 1));
    end
    return 16'($urandom);
  endfunction

  initial begin
    stim_row_t   row;
    logic        ok;
    logic [2:0]  cnt;
    logic [15:0] rx, ry;
    int          r;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = CFG_POWERED_ON;
    cfg_data       = '0;
    sample_valid   = 1'b0;
    read_ok        = 1'b0;
    touch_count    = '0;
    raw_x          = '0;
    raw_y          = '0;
    event_ready    = 1'b0;
    cfg_on         = 1'b1;
    cfg_resume     = 1'b0;
    cfg_sx         = 16'd3537;
    cfg_sy         = 16'd5880;
    cfg_pw         = 12'd640;
    cfg_ph         = 12'd960;
    cfg_nw         = 5'd6;
    cfg_ow         = 5'd10;
    finger_down_q  = 1'b0;
    filt_x         = '0;
    filt_y         = '0;
    error_count    = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    block_idle     = 1'b0;
    cur_fixed      = 1'b0;
    cur_fixed_has  = 1'b0;
    cur_fixed_ev   = '0;

    // Out-of-span and dropped samples, the corners of the default spans, then a release and presses.
    add_checked(1'b1, 3'd0, 16'd100, 16'd100, 1, 0, '0);
    add_checked(1'b0, 3'd1, 16'd100, 16'd100, 1, 0, '0);
    add_checked(1'b1, 3'd1, 16'd0, 16'd100, 1, 0, '0);
    add_checked(1'b1, 3'd2, 16'd3537, 16'd100, 1, 0, '0);
    add_checked(1'b1, 3'd4, 16'd100, 16'd0, 1, 0, '0);
    add_checked(1'b1, 3'd1, 16'd100, 16'd5880, 1, 0, '0);
    add_checked(1'b1, 3'd7, 16'hFFFF, 16'hFFFF, 1, 0, '0);
    add_checked(1'b1, 3'd1, 16'd1, 16'd5879, 1, 1,
                make_event(EV_PRESS, 0, 0, 1'b1, 0, 0));
    add_checked(1'b1, 3'd1, 16'd3536, 16'd1, 1, 1,
                make_event(EV_PRESS, 639, 959, 1'b1, 239, 359));
    add_checked(1'b1, 3'd0, 16'd0, 16'd0, 1, 1,
                make_event(EV_RELEASE, 0, 0, 1'b0, 239, 359));
    add_checked(1'b1, 3'd0, 16'd0, 16'd0, 1, 0, '0);
    add_checked(1'b1, 3'd7, 16'd1768, 16'd2940, 0, 0, '0);
    add_checked(1'b1, 3'd5, 16'd2500, 16'd1000, 0, 0, '0);
    // Panel powered off with the finger down, first without and then with resume mode.
    add_write(CFG_POWERED_ON, 16'd0);
    add_checked(1'b1, 3'd1, 16'd100, 16'd100, 1, 0, '0);
    add_write(CFG_RESUME_MODE, 16'd1);
    add_checked(1'b0, 3'd0, 16'd0, 16'd0, 0, 0, '0);
    add_checked(1'b1, 3'd1, 16'd100, 16'd100, 1, 0, '0);
    add_write(CFG_POWERED_ON, 16'd1);
    add_write(CFG_RESUME_MODE, 16'd0);
    // Largest panel and weights, so that the filter saturates.
    add_write(CFG_PANEL_WIDTH, 16'd4095);
    add_write(CFG_PANEL_HEIGHT, 16'd4095);
    add_write(CFG_NEW_WEIGHT, 16'd16);
    add_write(CFG_OLD_WEIGHT, 16'd16);
    add_checked(1'b1, 3'd1, 16'd3536, 16'd1, 0, 0, '0);
    add_checked(1'b1, 3'd1, 16'd3536, 16'd1, 1, 1,
                make_event(EV_PRESS, 4093, 4094, 1'b1, 4095, 4095));
    add_write(CFG_NEW_WEIGHT, 16'd0);
    add_write(CFG_OLD_WEIGHT, 16'd0);
    add_checked(1'b1, 3'd3, 16'd1000, 16'd1000, 0, 0, '0);
    add_checked(1'b1, 3'd0, 16'd0, 16'd0, 0, 0, '0);
    // A zero span admits no raw value, so nothing is pressed.
    add_write(CFG_SENSOR_X_SPAN, 16'd0);
    add_checked(1'b1, 3'd1, 16'd1, 16'd1, 1, 0, '0);
    add_write(CFG_SENSOR_X_SPAN, 16'hFFFF);
    add_write(CFG_SENSOR_Y_SPAN, 16'hFFFF);
    add_checked(1'b1, 3'd6, 16'hFFFE, 16'hFFFE, 0, 0, '0);
    add_checked(1'b1, 3'd1, 16'd1, 16'd1, 0, 0, '0);
    add_checked(1'b1, 3'd0, 16'd0, 16'd0, 0, 0, '0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CONFIG) begin
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.ok, row.cnt, row.rx, row.ry, row.fixed, row.fixed_has, row.ev);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(CFG_POWERED_ON, (ph % 5 == 2) ? 16'd0 : 16'd1);
      write_reg(CFG_RESUME_MODE, 16'($urandom_range(1)));
      write_reg(CFG_SENSOR_X_SPAN, pick_span());
      write_reg(CFG_SENSOR_Y_SPAN, pick_span());
      write_reg(CFG_PANEL_WIDTH, pick_panel());
      write_reg(CFG_PANEL_HEIGHT, pick_panel());
      write_reg(CFG_NEW_WEIGHT, pick_weight());
      write_reg(CFG_OLD_WEIGHT, pick_weight());
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && ph % 3 == 0) begin
          wait_for_quiet();
        end
        r   = $urandom_range(99);
        ok  = 1'b1;
        cnt = 3'($urandom_range(7, 1));
        rx  = pick_raw(cfg_sx);
        ry  = pick_raw(cfg_sy);
        if (r < 14) begin
          cnt = 3'd0;
        end else if (r < 22) begin
          cnt = 3'($urandom);
          rx  = 16'($urandom);
          ry  = 16'($urandom);
        end else if (r < 26) begin
          rx = $urandom_range(1) ? 16'd0 : cfg_sx;
          ry = $urandom_range(1) ? 16'd0 : cfg_sy;
        end else if (r < 30) begin
          ok  = 1'b0;
          cnt = 3'($urandom);
          rx  = 16'($urandom);
          ry  = 16'($urandom);
        end
        send_sample(ok, cnt, rx, ry, 0, 0, '0);
      end
      wait_for_quiet();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
